// File: rtl/usr_pkg.sv
// Shared types and constants for the unbounded sum reachability block.
package usr_pkg;

  // Sizing of the part store and the reachability map.
  localparam int unsigned MAX_PARTS  = 16;
  localparam int unsigned MAX_TARGET = 1023;

  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned PART_AW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned COUNT_W  = $clog2(MAX_PARTS + 1);
  localparam int unsigned MAP_DEPTH = MAX_TARGET + 1;
  localparam int unsigned MAP_AW   = $clog2(MAP_DEPTH);
  localparam int unsigned CMP_W    = (MAP_AW > VALUE_W) ? MAP_AW : VALUE_W;

  // Command codes carried in the request.
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } usr_cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PART_RD,
    ST_PART_CHK,
    ST_REACH_CHK
  } usr_state_e;

  // One command transfer.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
  } usr_req_t;

  // One result transfer.
  typedef struct packed {
    logic reachable;
    logic error;
  } usr_rsp_t;

endpackage

// File: rtl/usr_part_mem.sv
// Part value store: one write port, one read port with registered read data.
module usr_part_mem
  import usr_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [PART_AW-1:0] waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [PART_AW-1:0] raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem [MAX_PARTS];
  logic [VALUE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/usr_reach_mem.sv
// Reachability bitmap: one write port, one read port with registered read data.
module usr_reach_mem
  import usr_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [MAP_AW-1:0] waddr_i,
  input  logic              wdata_i,
  input  logic              re_i,
  input  logic [MAP_AW-1:0] raddr_i,
  output logic              rdata_o
);

  logic mem [MAP_DEPTH];
  logic rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/unbounded_sum_reachability_top.sv
// Top level: command decode, part count and the query sequencer.
//
// Usage: a command transfer happens at a rising edge with start high and
// busy low; req_i carries the command code and a 10-bit value. Add stores
// a nonzero part, clear empties the part set, query asks whether the
// target is a sum of stored parts, each usable any number of times.
// Every valid command gives exactly one result on rsp_o, marked by done_o
// for one cycle; the receiver must take it then, as it cannot stall.
// The unused command code gives no result.
// Add, clear, an out-of-range target and a zero target answer in the
// cycle after the transfer and keep busy low. Any other query sweeps the
// bitmap from 1 up to the target; for each target value the sequencer
// reads the stored parts one by one through the shared subtractor and
// checks the bitmap entry at t minus part. Each part goes through the
// part read and part check states, and through the bitmap check state
// when it is no larger than t; a hit closes the target value early.
// busy stays high for the whole sweep.
// Reset clears the part count and the sequencer; the stores themselves
// keep no reset value and are rewritten before they are read.
module unbounded_sum_reachability_top
  import usr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  usr_req_t req_i,
  output logic     done_o,
  output usr_rsp_t rsp_o
);

  usr_state_e         state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] k_q, k_d;
  logic [MAP_AW-1:0]  t_q, t_d;
  logic [MAP_AW-1:0]  tgt_q, tgt_d;
  logic               done_q, done_d;
  usr_rsp_t           rsp_q, rsp_d;

  logic               part_we, part_re;
  logic [PART_AW-1:0] part_waddr;
  logic [VALUE_W-1:0] part_rdata;
  logic               reach_we, reach_wdata, reach_re, reach_rdata;
  logic [MAP_AW-1:0]  reach_waddr;

  logic [CMP_W:0]     diff;
  logic               borrow;
  logic               fin, fin_hit;
  logic               too_large;

  // Part and bitmap storage.
  usr_part_mem u_part_mem (
    .clk_i   (clk_i),
    .we_i    (part_we),
    .waddr_i (part_waddr),
    .wdata_i (req_i.value),
    .re_i    (part_re),
    .raddr_i (k_q[PART_AW-1:0]),
    .rdata_o (part_rdata)
  );

  usr_reach_mem u_reach_mem (
    .clk_i   (clk_i),
    .we_i    (reach_we),
    .waddr_i (reach_waddr),
    .wdata_i (reach_wdata),
    .re_i    (reach_re),
    .raddr_i (diff[MAP_AW-1:0]),
    .rdata_o (reach_rdata)
  );

  // Shared subtractor: t minus the current part; the borrow means part > t.
  assign diff   = {1'b0, CMP_W'(t_q)} - {1'b0, CMP_W'(part_rdata)};
  assign borrow = diff[CMP_W];

  // Range check on the query target.
  assign too_large = {6'd0, req_i.value} > 16'(MAX_TARGET);

  assign part_waddr = count_q[PART_AW-1:0];

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    t_q   <= t_d;
    tgt_q <= tgt_d;
    rsp_q <= rsp_d;
  end

  // Next state, memory controls and results.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    t_d         = t_q;
    tgt_d       = tgt_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    part_we     = 1'b0;
    part_re     = 1'b0;
    reach_we    = 1'b0;
    reach_wdata = 1'b0;
    reach_waddr = t_q;
    reach_re    = 1'b0;
    fin         = 1'b0;
    fin_hit     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (usr_cmd_e'(req_i.cmd))
            CMD_ADD: begin
              done_d = 1'b1;
              rsp_d  = '0;
              if (req_i.value != '0) begin
                if (count_q == COUNT_W'(MAX_PARTS)) begin
                  rsp_d.error = 1'b1;
                end else begin
                  part_we = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end
            end
            CMD_QUERY: begin
              rsp_d = '0;
              if (too_large) begin
                done_d      = 1'b1;
                rsp_d.error = 1'b1;
              end else if (req_i.value == '0) begin
                done_d          = 1'b1;
                rsp_d.reachable = 1'b1;
              end else begin
                // Seed entry zero and start the sweep at one.
                reach_we    = 1'b1;
                reach_waddr = '0;
                reach_wdata = 1'b1;
                tgt_d       = MAP_AW'(req_i.value);
                t_d         = MAP_AW'(1);
                k_d         = '0;
                state_d     = ST_PART_RD;
              end
            end
            CMD_CLEAR: begin
              done_d  = 1'b1;
              rsp_d   = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PART_RD: begin
        // All parts tried without a hit: this target value is unreachable.
        if (k_q == count_q) begin
          fin = 1'b1;
        end else begin
          part_re = 1'b1;
          state_d = ST_PART_CHK;
        end
      end
      ST_PART_CHK: begin
        if (!borrow) begin
          reach_re = 1'b1;
          state_d  = ST_REACH_CHK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PART_RD;
        end
      end
      ST_REACH_CHK: begin
        if (reach_rdata) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PART_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Close out the current target value: record it, then move on or answer.
    if (fin) begin
      reach_we    = 1'b1;
      reach_waddr = t_q;
      reach_wdata = fin_hit;
      if (t_q == tgt_q) begin
        done_d          = 1'b1;
        rsp_d.reachable = fin_hit;
        rsp_d.error     = 1'b0;
        state_d         = ST_IDLE;
      end else begin
        t_d     = t_q + 1'b1;
        k_d     = '0;
        state_d = ST_PART_RD;
      end
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: verif/tb_unbounded_sum_reachability_top.sv
// Self-checking testbench for the unbounded sum reachability block.
module tb_unbounded_sum_reachability_top;
  import usr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 250000;
  // Cycles to wait after the last result for a stray one.
  localparam int unsigned TAIL_CYCLES = 16;

  // One pending command with the idle time that follows it.
  typedef struct {
    usr_req_t    req;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  usr_req_t req_i  = '0;
  logic     done_o;
  usr_rsp_t rsp_o;

  stim_t    pending_q[$];
  usr_rsp_t expected_rsp_q[$];

  // Shadow copy of the part set.
  logic [VALUE_W-1:0] shadow_parts [MAX_PARTS];
  int unsigned        shadow_count = 0;

  int unsigned cur_gap  = 0;
  int unsigned gap_cnt  = 0;
  int unsigned idle_cnt = 0;
  int unsigned err_cnt  = 0;
  bit          gaps_on  = 1'b1;

  // Tallies for the closing summary.
  int unsigned n_add = 0, n_query = 0, n_hit = 0, n_err = 0, n_clear = 0, n_unused = 0;

  unbounded_sum_reachability_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the shadow part set and work out its result.
  // Returns 0 when the command gives no result.
  function automatic bit sum_shadow_step(input usr_req_t rq, output usr_rsp_t rsp);
    bit reach [MAP_DEPTH];
    bit hit;
    rsp = '0;
    case (rq.cmd)
      CMD_ADD: begin
        if (rq.value != 0) begin
          if (shadow_count >= MAX_PARTS) begin
            rsp.error = 1'b1;
          end else begin
            shadow_parts[shadow_count] = rq.value;
            shadow_count++;
          end
        end
      end
      CMD_QUERY: begin
        if (rq.value > MAX_TARGET) begin
          rsp.error = 1'b1;
        end else begin
          // Fill the bitmap from 0 up to the target.
          reach[0] = 1'b1;
          for (int t = 1; t <= int'(rq.value); t++) begin
            hit = 1'b0;
            for (int k = 0; k < int'(shadow_count); k++) begin
              if (shadow_parts[k] != 0 && int'(shadow_parts[k]) <= t &&
                  reach[t - int'(shadow_parts[k])]) begin
                hit = 1'b1;
              end
            end
            reach[t] = hit;
          end
          rsp.reachable = reach[rq.value];
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Queue one command with a random idle time after it.
  task automatic queue_cmd(input logic [1:0] cmd, input int unsigned value, input bit drain);
    stim_t s;
    int unsigned r;
    r = $urandom_range(0, 99);
    s.req.cmd   = cmd;
    s.req.value = value[VALUE_W-1:0];
    s.drain     = drain;
    if (!gaps_on || r < 50) begin
      s.gap = 0;
    end else if (r < 90) begin
      s.gap = $urandom_range(1, 3);
    end else begin
      s.gap = $urandom_range(10, 60);
    end
    pending_q.push_back(s);
  endtask

  // Driver: presents queued commands and predicts each accepted transfer.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    usr_rsp_t    rsp;
    stim_t       head;
    bit          fire;
    int unsigned gap_left;
    if (!rst_ni) begin
      start   <= 1'b0;
      req_i   <= '0;
      gap_cnt <= 0;
      cur_gap <= 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        if (sum_shadow_step(req_i, rsp)) begin
          expected_rsp_q.push_back(rsp);
          case (req_i.cmd)
            CMD_ADD:   n_add++;
            CMD_QUERY: n_query++;
            default:   n_clear++;
          endcase
          if (rsp.reachable) n_hit++;
          if (rsp.error) n_err++;
        end else begin
          n_unused++;
        end
      end
      gap_left = fire ? cur_gap : gap_cnt;
      if (start && !fire) begin
        // Hold the command until the block takes it.
      end else if (gap_left != 0) begin
        start   <= 1'b0;
        gap_cnt <= gap_left - 1;
      end else if (pending_q.size() != 0 &&
                   (!pending_q[0].drain || expected_rsp_q.size() == 0)) begin
        head = pending_q.pop_front();
        start   <= 1'b1;
        req_i   <= head.req;
        cur_gap <= head.gap;
        gap_cnt <= 0;
      end else begin
        start   <= 1'b0;
        gap_cnt <= 0;
      end
    end
  end

  // Monitor: checks every result against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    usr_rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no command waiting: reachable %0d error %0d",
               rsp_o.reachable, rsp_o.error);
        err_cnt++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.reachable !== want.reachable) begin
          $error("reachable: expected %0d, got %0d", want.reachable, rsp_o.reachable);
          err_cnt++;
        end
        if (rsp_o.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, rsp_o.error);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: a run with no transfer for too long has hung.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= HANG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cnt);
      $display("unbounded_sum_reachability_top regression: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int unsigned n_rand, n_adds, n_q, big_left, r, val;
    logic [1:0]  c;
    int unsigned fill_vals [15] = '{7, 7, 12, 300, 451, 512, 999, 64, 128, 256, 33, 91,
                                    1000, 17, 850};

    // Directed: empty store, zero and largest targets and parts.
    queue_cmd(CMD_QUERY, 0, 1'b0);
    queue_cmd(CMD_QUERY, MAX_TARGET, 1'b0);
    queue_cmd(CMD_ADD, 0, 1'b0);
    queue_cmd(CMD_ADD, 1023, 1'b0);
    queue_cmd(CMD_QUERY, MAX_TARGET, 1'b0);
    queue_cmd(CMD_UNUSED, 1023, 1'b0);
    // Fill the store, with a duplicate part, then add one too many.
    foreach (fill_vals[i])
      queue_cmd(CMD_ADD, fill_vals[i], 1'b0);
    queue_cmd(CMD_ADD, 5, 1'b0);
    queue_cmd(CMD_QUERY, 1021, 1'b0);
    queue_cmd(CMD_CLEAR, 10'h2AA, 1'b1);
    queue_cmd(CMD_QUERY, 7, 1'b0);

    // Random: mostly clear, add and query sequences, some noise.
    n_rand   = 0;
    big_left = 3;
    while (n_rand < 75) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        c = 2'($urandom_range(0, 3));
        queue_cmd(c, $urandom_range(0, 1023), 1'b0);
        if (c != CMD_UNUSED) n_rand++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          queue_cmd(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 7) == 0);
          n_rand++;
        end
        n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
        for (int k = 0; k < int'(n_adds); k++) begin
          val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 40);
          queue_cmd(CMD_ADD, val, 1'b0);
          n_rand++;
        end
        n_q = $urandom_range(1, 3);
        for (int k = 0; k < int'(n_q); k++) begin
          r = $urandom_range(0, 19);
          if (r == 0 && big_left > 0) begin
            val = $urandom_range(512, 1023);
            big_left--;
          end else if (r < 4) begin
            val = $urandom_range(0, 255);
          end else begin
            val = $urandom_range(0, 63);
          end
          queue_cmd(CMD_QUERY, val, $urandom_range(0, 9) == 0);
          n_rand++;
        end
      end
    end

    // Hold reset, then release it away from the rising edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every command is taken and every result has come.
    while (pending_q.size() != 0 || start || expected_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds, %0d queries (%0d reachable), %0d clears, %0d unused codes.",
             n_add, n_query, n_hit, n_clear, n_unused);
    $display("Error results seen: %0d; mismatches: %0d.", n_err, err_cnt);
    if (err_cnt == 0) begin
      $display("unbounded_sum_reachability_top regression: pass");
    end else begin
      $display("unbounded_sum_reachability_top regression: fail");
    end
    $finish;
  end

endmodule
